### sv/scc_pkg.sv
`timescale 1ns / 1ps
package scc_pkg;

	// Fixed geometry of one item
	localparam int NV    = 4;   // vertices per item
	localparam int ND    = 3;   // coordinates per vertex
	localparam int NE    = 6;   // edges of a tetrahedron
	localparam int OUT_W = 48;  // result coordinate width

	// Edge slots
	localparam int E01 = 0;
	localparam int E02 = 1;
	localparam int E03 = 2;
	localparam int E12 = 3;
	localparam int E13 = 4;
	localparam int E23 = 5;

	// Configuration register indexes
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_DIMENSIONS = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_ZERO_TOL   = 1'b1;
	localparam int CFG_DATA_W = 32;

	localparam logic [1:0] DIM_TRI = 2'd2;

	// Result status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_DEGEN = 2'd1;
	localparam logic [1:0] ST_SAT   = 2'd2;

	localparam logic [OUT_W-1:0] SAT_POS = {1'b0, {(OUT_W-1){1'b1}}};
	localparam logic [OUT_W-1:0] SAT_NEG = {1'b1, {(OUT_W-1){1'b0}}};

	typedef struct packed {
		logic valid;
		logic two;
	} scc_ctl_t;

	typedef struct packed {
		logic valid;
		logic two;
		logic degen;
	} scc_dctl_t;

	typedef struct packed {
		logic [ND-1:0][OUT_W-1:0] center;
		logic [1:0]               status;
	} scc_res_t;

endpackage

### sv/simplex_circumcenter.sv
`timescale 1ns / 1ps
// Circumcenter of a triangle (dimensions = 2) or tetrahedron (any other value) given four
// integer vertices. The result is exact up to one rounding: each coordinate is the weighted
// vertex sum divided by the weight sum, rounded to FRAC_BITS fractional bits with ties away
// from zero, and clamped to 48 bits (status 2) when it does not fit. A weight sum whose
// magnitude is at or below zero_tolerance returns all zeros with status 1. In 2D mode the z
// inputs and vertex 3 are ignored and center_z is 0. The block takes one item per cycle while
// in_ready is high; the path from input transfer to result valid has 5 stages of edges and
// weights, 4 of weighted sums, 50 of the bit-per-stage divider (one stage per 48 result bits
// plus setup and seed), and one of rounding cleanup. The output holds a two-entry buffer, so
// in_ready falls only when a finished result is still waiting in its spare slot.
// Configuration is written through cfg_wr_en/cfg_addr/cfg_wdata and is to be changed only
// while no item is in flight.
module simplex_circumcenter #(
	parameter int COORD_WIDTH = 16,
	parameter int FRAC_BITS   = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_wr_en,
	input  logic [scc_pkg::CFG_IDX_W-1:0]        cfg_addr,
	input  logic [scc_pkg::CFG_DATA_W-1:0]       cfg_wdata,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic signed [COORD_WIDTH-1:0]        v0_x,
	input  logic signed [COORD_WIDTH-1:0]        v0_y,
	input  logic signed [COORD_WIDTH-1:0]        v0_z,
	input  logic signed [COORD_WIDTH-1:0]        v1_x,
	input  logic signed [COORD_WIDTH-1:0]        v1_y,
	input  logic signed [COORD_WIDTH-1:0]        v1_z,
	input  logic signed [COORD_WIDTH-1:0]        v2_x,
	input  logic signed [COORD_WIDTH-1:0]        v2_y,
	input  logic signed [COORD_WIDTH-1:0]        v2_z,
	input  logic signed [COORD_WIDTH-1:0]        v3_x,
	input  logic signed [COORD_WIDTH-1:0]        v3_y,
	input  logic signed [COORD_WIDTH-1:0]        v3_z,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic signed [scc_pkg::OUT_W-1:0]     center_x,
	output logic signed [scc_pkg::OUT_W-1:0]     center_y,
	output logic signed [scc_pkg::OUT_W-1:0]     center_z,
	output logic [1:0]                           status
);

	localparam int E_W = 2 * COORD_WIDTH + 2;
	localparam int W_W = 3 * E_W + 4;
	localparam int S_W = W_W + 2;
	localparam int N_W = W_W + COORD_WIDTH + 2;
	localparam int QW  = scc_pkg::OUT_W;

	logic [1:0]                     dims_q;
	logic [scc_pkg::CFG_DATA_W-1:0] tol_q;

	logic                           en;
	scc_pkg::scc_ctl_t              ctl_in;
	logic signed [COORD_WIDTH-1:0]  crd_in  [scc_pkg::NV][scc_pkg::ND];
	scc_pkg::scc_ctl_t              edge_ctl;
	logic signed [COORD_WIDTH-1:0]  edge_crd[scc_pkg::NV][scc_pkg::ND];
	logic signed [W_W-1:0]          edge_w  [scc_pkg::NV];
	scc_pkg::scc_dctl_t             mom_dctl;
	logic [N_W-1:0]                 mom_nmag[scc_pkg::ND];
	logic                           mom_neg [scc_pkg::ND];
	logic [S_W-1:0]                 mom_smag;
	scc_pkg::scc_dctl_t             fin_dctl;
	logic [QW-1:0]                  div_q   [scc_pkg::ND];
	logic                           div_neg [scc_pkg::ND];
	logic                           div_ovf [scc_pkg::ND];

	scc_pkg::scc_res_t              fin_res;
	scc_pkg::scc_res_t              out_res_q;
	scc_pkg::scc_res_t              skid_res_q;
	logic                           out_valid_q;
	logic                           skid_valid_q;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dims_q <= 2'd3;
			tol_q  <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_addr)
				scc_pkg::CFG_DIMENSIONS: dims_q <= cfg_wdata[1:0];
				scc_pkg::CFG_ZERO_TOL:   tol_q  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// The whole pipeline advances together; only a full spare output slot holds it
	assign en       = !skid_valid_q;
	assign in_ready = en;

	assign ctl_in = '{valid: in_valid, two: (dims_q == scc_pkg::DIM_TRI)};

	assign crd_in[0][0] = v0_x;
	assign crd_in[0][1] = v0_y;
	assign crd_in[0][2] = v0_z;
	assign crd_in[1][0] = v1_x;
	assign crd_in[1][1] = v1_y;
	assign crd_in[1][2] = v1_z;
	assign crd_in[2][0] = v2_x;
	assign crd_in[2][1] = v2_y;
	assign crd_in[2][2] = v2_z;
	assign crd_in[3][0] = v3_x;
	assign crd_in[3][1] = v3_y;
	assign crd_in[3][2] = v3_z;

	scc_edge #(
		.COORD_WIDTH(COORD_WIDTH)
	) u_edge (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.ctl_in (ctl_in),
		.crd_in (crd_in),
		.ctl_out(edge_ctl),
		.crd_out(edge_crd),
		.w_out  (edge_w)
	);

	scc_mom #(
		.COORD_WIDTH(COORD_WIDTH)
	) u_mom (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.tol     (tol_q),
		.ctl_in  (edge_ctl),
		.crd_in  (edge_crd),
		.w_in    (edge_w),
		.dctl_out(mom_dctl),
		.nmag_out(mom_nmag),
		.neg_out (mom_neg),
		.smag_out(mom_smag)
	);

	scc_div #(
		.COORD_WIDTH(COORD_WIDTH),
		.FRAC_BITS  (FRAC_BITS)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.dctl_in (mom_dctl),
		.nmag_in (mom_nmag),
		.neg_in  (mom_neg),
		.smag_in (mom_smag),
		.dctl_out(fin_dctl),
		.q_out   (div_q),
		.neg_out (div_neg),
		.ovf_out (div_ovf)
	);

	// Clamp, apply sign, drop z in 2D, and override everything for a degenerate simplex
	always_comb begin
		logic [QW-1:0] q;
		logic [QW-1:0] v;
		logic          sat;
		logic          sat_any;
		sat_any = 1'b0;
		fin_res = '0;
		for (int d = 0; d < scc_pkg::ND; d++) begin
			q   = div_q[d];
			sat = div_ovf[d] | (q[QW-1] & (!div_neg[d] | (|q[QW-2:0])));
			if (sat) begin
				v = div_neg[d] ? scc_pkg::SAT_NEG : scc_pkg::SAT_POS;
			end else begin
				v = div_neg[d] ? (QW'(0) - q) : q;
			end
			if (fin_dctl.two && d == scc_pkg::ND - 1) begin
				v   = '0;
				sat = 1'b0;
			end
			fin_res.center[d] = v;
			sat_any = sat_any | sat;
		end
		if (fin_dctl.degen) begin
			fin_res.center = '0;
			fin_res.status = scc_pkg::ST_DEGEN;
		end else begin
			fin_res.status = sat_any ? scc_pkg::ST_SAT : scc_pkg::ST_OK;
		end
	end

	// Output register plus a spare slot: a result arriving while the output is stalled
	// drops into the spare, and the pipeline holds until the spare drains.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (out_ready) begin
				skid_valid_q <= 1'b0;
			end
		end else if (fin_dctl.valid) begin
			if (!out_valid_q || out_ready) begin
				out_valid_q <= 1'b1;
			end else begin
				skid_valid_q <= 1'b1;
			end
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (out_ready) begin
				out_res_q <= skid_res_q;
			end
		end else if (fin_dctl.valid) begin
			if (!out_valid_q || out_ready) begin
				out_res_q <= fin_res;
			end else begin
				skid_res_q <= fin_res;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign center_x  = out_res_q.center[0];
	assign center_y  = out_res_q.center[1];
	assign center_z  = out_res_q.center[2];
	assign status    = out_res_q.status;

	// The spare slot only ever holds a result behind a full output register
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("spare output slot full while output register empty");

	// A held pipeline must not move its last stage
	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(fin_dctl))
		else $error("pipeline tail changed while stalled");

	// Degenerate results carry zero centers
	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == scc_pkg::ST_DEGEN) |->
		(center_x == '0 && center_y == '0 && center_z == '0))
		else $error("degenerate result with nonzero center");

endmodule

### sv/scc_edge.sv
`timescale 1ns / 1ps
// Squared edges, pair products and barycentric weights (stages 1 to 5).
module scc_edge #(
	parameter int COORD_WIDTH = 16,
	localparam int E_W = 2 * COORD_WIDTH + 2,
	localparam int W_W = 3 * E_W + 4
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  scc_pkg::scc_ctl_t             ctl_in,
	input  logic signed [COORD_WIDTH-1:0] crd_in  [scc_pkg::NV][scc_pkg::ND],
	output scc_pkg::scc_ctl_t             ctl_out,
	output logic signed [COORD_WIDTH-1:0] crd_out [scc_pkg::NV][scc_pkg::ND],
	output logic signed [W_W-1:0]         w_out   [scc_pkg::NV]
);

	localparam int NP  = 7;
	localparam int NT  = 16;
	localparam int FW  = E_W + 2;
	localparam int PPW = E_W + 1 + FW;

	localparam int EA [scc_pkg::NE] = '{0, 0, 0, 1, 1, 2};
	localparam int EB [scc_pkg::NE] = '{1, 2, 3, 2, 3, 3};

	// Distinct edge pair products of the 3D weights
	localparam int PA [NP] = '{scc_pkg::E13, scc_pkg::E03, scc_pkg::E03, scc_pkg::E01,
		scc_pkg::E02, scc_pkg::E03, scc_pkg::E02};
	localparam int PB [NP] = '{scc_pkg::E23, scc_pkg::E23, scc_pkg::E13, scc_pkg::E23,
		scc_pkg::E13, scc_pkg::E12, scc_pkg::E12};
	// 2D: the first pair slots hold a single edge
	localparam int P2 [NP] = '{scc_pkg::E12, scc_pkg::E02, scc_pkg::E01, 0, 0, 0, 0};

	localparam int TP [NT] = '{0, 3, 4, 5, 1, 3, 4, 5, 2, 4, 3, 5, 6, 5, 3, 4};
	localparam int FA [NT] = '{
		scc_pkg::E12, scc_pkg::E13, scc_pkg::E12, scc_pkg::E13,
		scc_pkg::E02, scc_pkg::E02, scc_pkg::E03, scc_pkg::E02,
		scc_pkg::E01, scc_pkg::E01, scc_pkg::E03, scc_pkg::E01,
		scc_pkg::E01, scc_pkg::E01, scc_pkg::E02, scc_pkg::E01};
	localparam int FB [NT] = '{
		scc_pkg::E12, scc_pkg::E12, scc_pkg::E23, scc_pkg::E23,
		scc_pkg::E02, scc_pkg::E03, scc_pkg::E23, scc_pkg::E23,
		scc_pkg::E01, scc_pkg::E03, scc_pkg::E13, scc_pkg::E13,
		scc_pkg::E01, scc_pkg::E02, scc_pkg::E12, scc_pkg::E12};
	localparam int FC [NT] = '{
		scc_pkg::E12, scc_pkg::E23, scc_pkg::E13, scc_pkg::E12,
		scc_pkg::E02, scc_pkg::E23, scc_pkg::E02, scc_pkg::E03,
		scc_pkg::E01, scc_pkg::E13, scc_pkg::E01, scc_pkg::E03,
		scc_pkg::E01, scc_pkg::E12, scc_pkg::E01, scc_pkg::E02};
	localparam int F2A [scc_pkg::NV] = '{scc_pkg::E01, scc_pkg::E01, scc_pkg::E02, 0};
	localparam int F2B [scc_pkg::NV] = '{scc_pkg::E02, scc_pkg::E12, scc_pkg::E12, 0};
	localparam int F2C [scc_pkg::NV] = '{scc_pkg::E12, scc_pkg::E02, scc_pkg::E01, 0};

	function automatic logic [E_W-1:0] edge_sq(
		input logic signed [COORD_WIDTH-1:0] p [scc_pkg::ND],
		input logic signed [COORD_WIDTH-1:0] q [scc_pkg::ND],
		input logic                          two
	);
		logic signed [COORD_WIDTH:0] d;
		logic signed [E_W-1:0]       sq;
		logic [E_W-1:0]              acc;
		acc = '0;
		for (int i = 0; i < scc_pkg::ND; i++) begin
			d  = (COORD_WIDTH+1)'(p[i]) - (COORD_WIDTH+1)'(q[i]);
			sq = d * d;
			if (!(two && i == scc_pkg::ND - 1)) begin
				acc = acc + $unsigned(sq);
			end
		end
		return acc;
	endfunction

	function automatic logic signed [FW-1:0] lin(
		input logic [E_W-1:0] a,
		input logic [E_W-1:0] b,
		input logic [E_W-1:0] c
	);
		return $signed({2'b00, a}) + $signed({2'b00, b}) - $signed({2'b00, c});
	endfunction

	scc_pkg::scc_ctl_t             ctl_s1, ctl_s2, ctl_s3, ctl_s4, ctl_s5;
	logic signed [COORD_WIDTH-1:0] crd_s1 [scc_pkg::NV][scc_pkg::ND];
	logic signed [COORD_WIDTH-1:0] crd_s2 [scc_pkg::NV][scc_pkg::ND];
	logic signed [COORD_WIDTH-1:0] crd_s3 [scc_pkg::NV][scc_pkg::ND];
	logic signed [COORD_WIDTH-1:0] crd_s4 [scc_pkg::NV][scc_pkg::ND];
	logic signed [COORD_WIDTH-1:0] crd_s5 [scc_pkg::NV][scc_pkg::ND];
	logic [E_W-1:0]                e_c    [scc_pkg::NE];
	logic [E_W-1:0]                e_s1   [scc_pkg::NE];
	logic [2*E_W-1:0]              pair_c [NP];
	logic [2*E_W-1:0]              pair_s2[NP];
	logic signed [FW-1:0]          ff_c   [NT];
	logic signed [FW-1:0]          ff_s2  [NT];
	logic signed [PPW-1:0]         plo_s3 [NT];
	logic signed [PPW-1:0]         phi_s3 [NT];
	logic signed [W_W-1:0]         t_s4   [NT];
	logic signed [W_W-1:0]         w_s5   [scc_pkg::NV];

	always_comb begin
		for (int k = 0; k < scc_pkg::NE; k++) begin
			e_c[k] = edge_sq(crd_in[EA[k]], crd_in[EB[k]], ctl_in.two);
		end
	end

	// 2D swaps the product for a lone edge in the first slots
	always_comb begin
		for (int p = 0; p < NP; p++) begin
			if (ctl_s1.two && p < 3) begin
				pair_c[p] = {{E_W{1'b0}}, e_s1[P2[p]]};
			end else begin
				pair_c[p] = e_s1[PA[p]] * e_s1[PB[p]];
			end
		end
		for (int i = 0; i < scc_pkg::NV; i++) begin
			for (int t = 0; t < 4; t++) begin
				if (ctl_s1.two) begin
					ff_c[i*4+t] = (t == 0 && i < 3) ?
						lin(e_s1[F2A[i]], e_s1[F2B[i]], e_s1[F2C[i]]) : '0;
				end else if (t == 0) begin
					ff_c[i*4+t] = FW'(0) - $signed({1'b0, e_s1[FA[i*4+t]], 1'b0});
				end else begin
					ff_c[i*4+t] = lin(e_s1[FA[i*4+t]], e_s1[FB[i*4+t]], e_s1[FC[i*4+t]]);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
			ctl_s4 <= '0;
			ctl_s5 <= '0;
		end else if (en) begin
			ctl_s1 <= ctl_in;
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
			ctl_s4 <= ctl_s3;
			ctl_s5 <= ctl_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			crd_s1 <= crd_in;
			crd_s2 <= crd_s1;
			crd_s3 <= crd_s2;
			crd_s4 <= crd_s3;
			crd_s5 <= crd_s4;
			e_s1   <= e_c;
			pair_s2 <= pair_c;
			ff_s2  <= ff_c;
			for (int k = 0; k < NT; k++) begin
				plo_s3[k] <= $signed({1'b0, pair_s2[TP[k]][E_W-1:0]}) * ff_s2[k];
				phi_s3[k] <= $signed({1'b0, pair_s2[TP[k]][2*E_W-1:E_W]}) * ff_s2[k];
				t_s4[k]   <= (W_W'(phi_s3[k]) <<< E_W) + W_W'(plo_s3[k]);
			end
			for (int i = 0; i < scc_pkg::NV; i++) begin
				w_s5[i] <= t_s4[i*4] + t_s4[i*4+1] + t_s4[i*4+2] + t_s4[i*4+3];
			end
		end
	end

	assign ctl_out = ctl_s5;
	assign crd_out = crd_s5;
	assign w_out   = w_s5;

endmodule

### sv/scc_mom.sv
`timescale 1ns / 1ps
// Weight sum and weighted vertex sums, magnitudes and signs (stages 6 to 9).
module scc_mom #(
	parameter int COORD_WIDTH = 16,
	localparam int E_W = 2 * COORD_WIDTH + 2,
	localparam int W_W = 3 * E_W + 4,
	localparam int S_W = W_W + 2,
	localparam int N_W = W_W + COORD_WIDTH + 2
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic [scc_pkg::CFG_DATA_W-1:0] tol,
	input  scc_pkg::scc_ctl_t             ctl_in,
	input  logic signed [COORD_WIDTH-1:0] crd_in [scc_pkg::NV][scc_pkg::ND],
	input  logic signed [W_W-1:0]         w_in   [scc_pkg::NV],
	output scc_pkg::scc_dctl_t            dctl_out,
	output logic [N_W-1:0]                nmag_out [scc_pkg::ND],
	output logic                          neg_out  [scc_pkg::ND],
	output logic [S_W-1:0]                smag_out
);

	localparam int WL  = W_W / 2;
	localparam int WH  = W_W - WL;
	localparam int MLW = WL + 1 + COORD_WIDTH;
	localparam int MHW = WH + COORD_WIDTH;
	localparam int M_W = W_W + COORD_WIDTH;

	scc_pkg::scc_ctl_t  ctl_s6, ctl_s7, ctl_s8;
	scc_pkg::scc_dctl_t dctl_s9;
	logic signed [MLW-1:0] ml_s6 [scc_pkg::NV][scc_pkg::ND];
	logic signed [MHW-1:0] mh_s6 [scc_pkg::NV][scc_pkg::ND];
	logic signed [S_W-1:0] s_s6;
	logic signed [M_W-1:0] m_s7  [scc_pkg::NV][scc_pkg::ND];
	logic [S_W-1:0]        smag_s7, smag_s8, smag_s9;
	logic                  sneg_s7, sneg_s8;
	logic                  degen_s8;
	logic signed [N_W-1:0] n_s8  [scc_pkg::ND];
	logic [N_W-1:0]        nmag_s9 [scc_pkg::ND];
	logic                  neg_s9  [scc_pkg::ND];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s6  <= '0;
			ctl_s7  <= '0;
			ctl_s8  <= '0;
			dctl_s9 <= '0;
		end else if (en) begin
			ctl_s6  <= ctl_in;
			ctl_s7  <= ctl_s6;
			ctl_s8  <= ctl_s7;
			dctl_s9 <= '{valid: ctl_s8.valid, two: ctl_s8.two, degen: degen_s8};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// Split each weight so every multiply stays narrow
			for (int i = 0; i < scc_pkg::NV; i++) begin
				for (int d = 0; d < scc_pkg::ND; d++) begin
					ml_s6[i][d] <= $signed({1'b0, w_in[i][WL-1:0]}) * crd_in[i][d];
					mh_s6[i][d] <= $signed(w_in[i][W_W-1:WL]) * crd_in[i][d];
					m_s7[i][d]  <= (M_W'(mh_s6[i][d]) <<< WL) + M_W'(ml_s6[i][d]);
				end
			end
			s_s6 <= S_W'(w_in[0]) + S_W'(w_in[1]) + S_W'(w_in[2]) + S_W'(w_in[3]);

			sneg_s7 <= s_s6[S_W-1];
			smag_s7 <= s_s6[S_W-1] ? $unsigned(-s_s6) : $unsigned(s_s6);

			for (int d = 0; d < scc_pkg::ND; d++) begin
				n_s8[d] <= N_W'(m_s7[0][d]) + N_W'(m_s7[1][d]) + N_W'(m_s7[2][d])
					+ N_W'(m_s7[3][d]);
			end
			smag_s8  <= smag_s7;
			sneg_s8  <= sneg_s7;
			degen_s8 <= smag_s7 <= S_W'(tol);

			for (int d = 0; d < scc_pkg::ND; d++) begin
				nmag_s9[d] <= n_s8[d][N_W-1] ? $unsigned(-n_s8[d]) : $unsigned(n_s8[d]);
				neg_s9[d]  <= n_s8[d][N_W-1] ^ sneg_s8;
			end
			smag_s9 <= smag_s8;
		end
	end

	assign dctl_out = dctl_s9;
	assign nmag_out = nmag_s9;
	assign neg_out  = neg_s9;
	assign smag_out = smag_s9;

endmodule

### sv/scc_div.sv
`timescale 1ns / 1ps
// Pipelined restoring divider, three lanes, one quotient bit per stage.
module scc_div #(
	parameter int COORD_WIDTH = 16,
	parameter int FRAC_BITS   = 16,
	localparam int E_W = 2 * COORD_WIDTH + 2,
	localparam int W_W = 3 * E_W + 4,
	localparam int S_W = W_W + 2,
	localparam int N_W = W_W + COORD_WIDTH + 2
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  scc_pkg::scc_dctl_t           dctl_in,
	input  logic [N_W-1:0]               nmag_in [scc_pkg::ND],
	input  logic                         neg_in  [scc_pkg::ND],
	input  logic [S_W-1:0]               smag_in,
	output scc_pkg::scc_dctl_t           dctl_out,
	output logic [scc_pkg::OUT_W-1:0]    q_out   [scc_pkg::ND],
	output logic                         neg_out [scc_pkg::ND],
	output logic                         ovf_out [scc_pkg::ND]
);

	localparam int QW    = scc_pkg::OUT_W;
	localparam int NUM_W = N_W + FRAC_BITS + 2;
	localparam int DEN_W = S_W + 1;
	localparam int R0W   = NUM_W - QW;
	localparam int CMP_W = (R0W > DEN_W) ? R0W : DEN_W;

	scc_pkg::scc_dctl_t dctl_s10;
	logic [NUM_W-1:0]   num_s10 [scc_pkg::ND];
	logic [DEN_W-1:0]   den_s10;
	logic               neg_s10 [scc_pkg::ND];

	scc_pkg::scc_dctl_t dctl_s [QW+1];
	logic [DEN_W-1:0]   den_s  [QW+1];
	logic [DEN_W-1:0]   rem_s  [QW+1][scc_pkg::ND];
	logic [QW-1:0]      qn_s   [QW+1][scc_pkg::ND];
	logic               neg_s  [QW+1][scc_pkg::ND];
	logic               ovf_s  [QW+1][scc_pkg::ND];

	// Round half away: (2|n| * 2^F + |s|) / (2|s|)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dctl_s10 <= '0;
			dctl_s[0] <= '0;
		end else if (en) begin
			dctl_s10 <= dctl_in;
			dctl_s[0] <= dctl_s10;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int d = 0; d < scc_pkg::ND; d++) begin
				num_s10[d] <= (NUM_W'(nmag_in[d]) << (FRAC_BITS + 1)) + NUM_W'(smag_in);
				neg_s10[d] <= neg_in[d];
			end
			den_s10 <= {smag_in, 1'b0};
		end
	end

	// Top bits seed the remainder; a seed at or above the divisor overflows
	for (genvar d = 0; d < scc_pkg::ND; d++) begin : g_seed
		logic [CMP_W-1:0] r0;
		assign r0 = CMP_W'(num_s10[d][NUM_W-1:QW]);
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[0][d] <= r0[DEN_W-1:0];
				qn_s[0][d]  <= num_s10[d][QW-1:0];
				ovf_s[0][d] <= r0 >= CMP_W'(den_s10);
				neg_s[0][d] <= neg_s10[d];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			den_s[0] <= den_s10;
		end
	end

	for (genvar j = 0; j < QW; j++) begin : g_step
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dctl_s[j+1] <= '0;
			end else if (en) begin
				dctl_s[j+1] <= dctl_s[j];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				den_s[j+1] <= den_s[j];
			end
		end
		for (genvar d = 0; d < scc_pkg::ND; d++) begin : g_lane
			logic [DEN_W:0] t;
			logic           ge;
			assign t  = {rem_s[j][d], qn_s[j][d][QW-1]};
			assign ge = t >= {1'b0, den_s[j]};
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[j+1][d] <= ge ? DEN_W'(t - {1'b0, den_s[j]}) : DEN_W'(t);
					qn_s[j+1][d]  <= {qn_s[j][d][QW-2:0], ge};
					neg_s[j+1][d] <= neg_s[j][d];
					ovf_s[j+1][d] <= ovf_s[j][d];
				end
			end
		end
	end

	assign dctl_out = dctl_s[QW];
	assign q_out    = qn_s[QW];
	assign neg_out  = neg_s[QW];
	assign ovf_out  = ovf_s[QW];

endmodule

### verif/tb_top.sv
`timescale 1ns / 1ps
module tb_top;

	localparam int CW       = 16;
	localparam int FB       = 16;
	localparam int SETTLE   = 100;   // comfortably above the pipeline latency
	localparam int WATCHDOG = 5000;  // idle cycles without any transfer before giving up

	typedef logic signed [255:0] wide_t;
	typedef logic [11:0][CW-1:0] simplex_t;   // v0 xyz, v1 xyz, v2 xyz, v3 xyz

	typedef struct packed {
		logic [scc_pkg::OUT_W-1:0] cx;
		logic [scc_pkg::OUT_W-1:0] cy;
		logic [scc_pkg::OUT_W-1:0] cz;
		logic [1:0]                st;
	} center_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic [scc_pkg::CFG_IDX_W-1:0] cfg_addr = '0;
	logic [scc_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	simplex_t vin = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [scc_pkg::OUT_W-1:0] center_x, center_y, center_z;
	logic [1:0] status;

	simplex_t simplex_q[$];     // simplices waiting to be driven
	center_t  center_q[$];      // predicted centers waiting for the output
	logic [1:0]  dims_reg = 2'd3;
	logic [31:0] tol_reg  = '0;
	bit hold_send = 0;
	int errors = 0;
	int idle_cycles = 0;

	always #4 clk = ~clk;

	simplex_circumcenter #(.COORD_WIDTH(CW), .FRAC_BITS(FB)) dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_ready(in_ready),
		.v0_x(vin[0]), .v0_y(vin[1]), .v0_z(vin[2]),
		.v1_x(vin[3]), .v1_y(vin[4]), .v1_z(vin[5]),
		.v2_x(vin[6]), .v2_y(vin[7]), .v2_z(vin[8]),
		.v3_x(vin[9]), .v3_y(vin[10]), .v3_z(vin[11]),
		.out_valid(out_valid), .out_ready(out_ready),
		.center_x(center_x), .center_y(center_y), .center_z(center_z),
		.status(status)
	);

	// a * b * (x + y - z)
	function automatic wide_t tri_term(wide_t a, wide_t b, wide_t x, wide_t y, wide_t z);
		return a * b * (x + y - z);
	endfunction

	function automatic wide_t cube_term(wide_t a, wide_t b, wide_t c);
		return -wide_t'(2) * a * b * c;
	endfunction

	// Exact circumcenter: barycentric weights from squared edges, one rounded division.
	function automatic center_t circumcenter(simplex_t v, logic [1:0] dims, logic [31:0] tol);
		wide_t p[4][3];
		wide_t e[scc_pkg::NE];
		wide_t w[4];
		wide_t s, n, an, ad, q, lim;
		int ea[scc_pkg::NE];
		int eb[scc_pkg::NE];
		logic [scc_pkg::OUT_W-1:0] c[3];
		bit two, sat, neg;
		int nv, nd;
		center_t r;
		two = (dims == scc_pkg::DIM_TRI);
		nv = two ? 3 : 4;
		nd = two ? 2 : 3;
		ea = '{0, 0, 0, 1, 1, 2};
		eb = '{1, 2, 3, 2, 3, 3};
		for (int i = 0; i < 4; i++)
			for (int d = 0; d < 3; d++)
				p[i][d] = wide_t'($signed(v[i*3+d]));
		for (int k = 0; k < scc_pkg::NE; k++) begin
			e[k] = 0;
			for (int d = 0; d < nd; d++)
				e[k] += (p[ea[k]][d] - p[eb[k]][d]) * (p[ea[k]][d] - p[eb[k]][d]);
		end
		if (two) begin
			w[0] = e[scc_pkg::E12] * (e[scc_pkg::E01] + e[scc_pkg::E02] - e[scc_pkg::E12]);
			w[1] = e[scc_pkg::E02] * (e[scc_pkg::E01] + e[scc_pkg::E12] - e[scc_pkg::E02]);
			w[2] = e[scc_pkg::E01] * (e[scc_pkg::E02] + e[scc_pkg::E12] - e[scc_pkg::E01]);
			w[3] = 0;
		end else begin
			w[0] = cube_term(e[scc_pkg::E12], e[scc_pkg::E13], e[scc_pkg::E23])
				+ tri_term(e[scc_pkg::E01], e[scc_pkg::E23], e[scc_pkg::E13],
					e[scc_pkg::E12], e[scc_pkg::E23])
				+ tri_term(e[scc_pkg::E02], e[scc_pkg::E13], e[scc_pkg::E12],
					e[scc_pkg::E23], e[scc_pkg::E13])
				+ tri_term(e[scc_pkg::E03], e[scc_pkg::E12], e[scc_pkg::E13],
					e[scc_pkg::E23], e[scc_pkg::E12]);
			w[1] = cube_term(e[scc_pkg::E02], e[scc_pkg::E03], e[scc_pkg::E23])
				+ tri_term(e[scc_pkg::E01], e[scc_pkg::E23], e[scc_pkg::E02],
					e[scc_pkg::E03], e[scc_pkg::E23])
				+ tri_term(e[scc_pkg::E13], e[scc_pkg::E02], e[scc_pkg::E03],
					e[scc_pkg::E23], e[scc_pkg::E02])
				+ tri_term(e[scc_pkg::E12], e[scc_pkg::E03], e[scc_pkg::E02],
					e[scc_pkg::E23], e[scc_pkg::E03]);
			w[2] = cube_term(e[scc_pkg::E01], e[scc_pkg::E03], e[scc_pkg::E13])
				+ tri_term(e[scc_pkg::E02], e[scc_pkg::E13], e[scc_pkg::E01],
					e[scc_pkg::E03], e[scc_pkg::E13])
				+ tri_term(e[scc_pkg::E23], e[scc_pkg::E01], e[scc_pkg::E03],
					e[scc_pkg::E13], e[scc_pkg::E01])
				+ tri_term(e[scc_pkg::E12], e[scc_pkg::E03], e[scc_pkg::E01],
					e[scc_pkg::E13], e[scc_pkg::E03]);
			w[3] = cube_term(e[scc_pkg::E01], e[scc_pkg::E02], e[scc_pkg::E12])
				+ tri_term(e[scc_pkg::E03], e[scc_pkg::E12], e[scc_pkg::E01],
					e[scc_pkg::E02], e[scc_pkg::E12])
				+ tri_term(e[scc_pkg::E23], e[scc_pkg::E01], e[scc_pkg::E02],
					e[scc_pkg::E12], e[scc_pkg::E01])
				+ tri_term(e[scc_pkg::E13], e[scc_pkg::E02], e[scc_pkg::E01],
					e[scc_pkg::E12], e[scc_pkg::E02]);
		end
		s = 0;
		for (int i = 0; i < nv; i++) s += w[i];
		r = '0;
		ad = (s < 0) ? -s : s;
		// degenerate: everything zero, status flagged
		if (ad <= wide_t'({1'b0, tol})) begin
			r.st = scc_pkg::ST_DEGEN;
			return r;
		end
		sat = 0;
		c = '{default: '0};
		for (int d = 0; d < nd; d++) begin
			n = 0;
			for (int i = 0; i < nv; i++) n += w[i] * p[i][d];
			neg = (n < 0) != (s < 0);
			an = (n < 0) ? -n : n;
			// round half away from zero: (2|n|*2^F + |s|) / (2|s|)
			q = ((an << (FB + 1)) + ad) / (ad << 1);
			lim = neg ? (wide_t'(1) << (scc_pkg::OUT_W - 1))
				: ((wide_t'(1) << (scc_pkg::OUT_W - 1)) - 1);
			if (q > lim) begin
				sat = 1;
				q = lim;
			end
			if (neg) q = -q;
			c[d] = q[scc_pkg::OUT_W-1:0];
		end
		r.cx = c[0];
		r.cy = c[1];
		r.cz = c[2];
		r.st = sat ? scc_pkg::ST_SAT : scc_pkg::ST_OK;
		return r;
	endfunction

	function automatic logic [CW-1:0] rnd_in(int lo, int hi);
		return CW'($urandom_range(hi - lo, 0) + lo);
	endfunction

	// Random simplex: full range, tiny grid, collinear/coplanar, or nearly so.
	function automatic simplex_t rnd_simplex();
		simplex_t v;
		int kind, bx, dv, ka, kb, span;
		kind = $urandom_range(9, 0);
		if (kind <= 3) begin
			for (int i = 0; i < 12; i++) v[i] = CW'($urandom);
		end else if (kind <= 5) begin
			for (int i = 0; i < 12; i++) v[i] = rnd_in(-4, 4);
		end else begin
			span = (kind == 9) ? 300 : 100;
			for (int d = 0; d < 3; d++) begin
				bx = $urandom_range(400, 0) - 200;
				dv = $urandom_range(2 * span, 0) - span;
				v[d] = CW'(bx);
				v[3+d] = CW'(bx + dv);
				ka = $urandom_range(20, 0) - 10;
				v[6+d] = CW'(bx + ka * dv);
				kb = $urandom_range(20, 0) - 10;
				v[9+d] = CW'(bx + kb * dv);
			end
			// nudge one coordinate off the line/plane for near-degenerate cases
			if (kind >= 8) v[$urandom_range(11, 6)] += CW'($urandom_range(2, 0) - 1);
		end
		return v;
	endfunction

	// append a simplex to the pending queue
	function automatic void queue_simplex(simplex_t v);
		simplex_q = {simplex_q, v};
	endfunction

	task automatic cfg_write(logic [scc_pkg::CFG_IDX_W-1:0] idx, logic [31:0] val);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_addr  <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		if (idx == scc_pkg::CFG_DIMENSIONS) dims_reg = val[1:0];
		else tol_reg = val;
	endtask

	// hold until nothing is in flight, then give the pipeline time to empty
	task automatic drain();
		while (simplex_q.size() > 0 || in_valid || center_q.size() > 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic report(string what, logic [scc_pkg::OUT_W-1:0] got,
		logic [scc_pkg::OUT_W-1:0] want);
		errors++;
		$display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
	endtask

	// Driver: bursts of transfers separated by random gaps.
	int burst_left = 4;
	int gap_left = 0;
	simplex_t held;
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				center_q = {center_q, circumcenter(held, dims_reg, tol_reg)};
			end
			if (!(in_valid && !in_ready)) begin
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
					in_valid <= 1'b0;
				end else if (simplex_q.size() > 0 && !hold_send) begin
					held = simplex_q.pop_front();
					vin <= held;
					in_valid <= 1'b1;
					if (burst_left <= 1) begin
						burst_left <= $urandom_range(24, 1);
						gap_left <= ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(12, 1);
					end else begin
						burst_left <= burst_left - 1;
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: a free-running counter redraws the receiver stall pattern at random; compare each transfer.
	int stall_mode = 0;
	int stall_cnt = 0;
	center_t want;
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (center_q.size() == 0) begin
					report("unexpected result", center_x, '0);
				end else begin
					want = center_q.pop_front();
					if (center_x !== want.cx) report("center_x", center_x, want.cx);
					if (center_y !== want.cy) report("center_y", center_y, want.cy);
					if (center_z !== want.cz) report("center_z", center_z, want.cz);
					if (status !== want.st)
						report("status", scc_pkg::OUT_W'(status), scc_pkg::OUT_W'(want.st));
				end
			end
			stall_cnt <= stall_cnt + 1;
			if (stall_cnt % 64 == 63) stall_mode <= $urandom_range(3, 0);
			case (stall_mode)
				0: out_ready <= 1'b1;
				1: out_ready <= $urandom_range(1, 0);
				2: out_ready <= ($urandom_range(7, 0) == 0);
				default: out_ready <= ((stall_cnt / 5) % 3) != 0;
			endcase
		end
	end

	// Watchdog: count cycles with no transfer on either side.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				idle_cycles <= 0;
			end else begin
				idle_cycles <= idle_cycles + 1;
				if (idle_cycles >= WATCHDOG) begin
					$display("Some tests failed");
					$finish;
				end
			end
		end
	end

	logic [1:0]  dims_set[8] = '{2'd3, 2'd2, 2'd2, 2'd3, 2'd0, 2'd1, 2'd2, 2'd3};
	logic [31:0] tol_set[8]  = '{32'd0, 32'd0, 32'hFFFFFFFF, 32'hFFFFFFFF,
		32'd1000, 32'd0, 32'd5, 32'd0};
	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: extremes, zero simplex, textbook shapes, collinear, near-flat huge span
		queue_simplex('0);
		queue_simplex({12{16'h7FFF}});
		queue_simplex({12{16'h8000}});
		queue_simplex({12{16'hFFFF}});
		queue_simplex({16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000,
			16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000});
		// vertex list is v3z..v0x from left to right
		queue_simplex({16'd2, 16'd0, 16'd0, 16'd0, 16'd2, 16'd0,
			16'd0, 16'd0, 16'd2, 16'd0, 16'd0, 16'd0});
		queue_simplex({16'd3, 16'd1, 16'd5, 16'd0, 16'd4, 16'd0,
			16'd0, 16'd0, 16'd4, 16'd0, 16'd0, 16'd0});
		queue_simplex({16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000,
			16'h7FFF, 16'h8000, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF});
		queue_simplex({16'd0, 16'd3, 16'd3, 16'd0, 16'd2, 16'd2,
			16'd0, 16'd1, 16'd1, 16'd0, 16'd0, 16'd0});
		queue_simplex({16'h0001, 16'h0000, 16'h0000, 16'h0000, 16'h0001, 16'h7FFF,
			16'h0000, 16'h7FFF, 16'h7FFF, 16'h0000, 16'h8000, 16'h8000});
		queue_simplex({16'h0000, 16'h0000, 16'h0001, 16'h0000, 16'h0000, 16'h7FFF,
			16'h0001, 16'h0001, 16'h0000, 16'h0000, 16'h8000, 16'h8000});
		drain();

		for (int ph = 0; ph < 8; ph++) begin
			cfg_write(scc_pkg::CFG_DIMENSIONS, {30'd0, dims_set[ph]});
			cfg_write(scc_pkg::CFG_ZERO_TOL, tol_set[ph]);
			if (ph == 1) begin
				// 2D directed: right triangle, collinear, flat with huge span
				queue_simplex({16'd9, 16'd9, 16'd9, 16'd5, 16'd4, 16'd0,
					16'd7, 16'd0, 16'd4, 16'd1, 16'd0, 16'd0});
				queue_simplex({16'd0, 16'd0, 16'd0, 16'd0, 16'd6, 16'd6,
					16'd0, 16'd3, 16'd3, 16'd0, 16'd1, 16'd1});
				queue_simplex({16'd0, 16'd0, 16'd0, 16'd0, 16'h0001, 16'h0000,
					16'd0, 16'h7FFF, 16'h7FFF, 16'd0, 16'h8000, 16'h8000});
			end
			for (int k = 0; k < 240; k++) begin
				queue_simplex(rnd_simplex());
				if (ph == 3 && k == 120) begin
					// sender pauses mid-phase until every result is back
					while (simplex_q.size() > 0 || in_valid) @(posedge clk);
					hold_send = 1;
					while (center_q.size() > 0) @(posedge clk);
					hold_send = 0;
				end
			end
			drain();
		end

		if (errors == 0 && center_q.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end
endmodule
